// ===== hdl/rct_pkg.sv =====
package rct_pkg;

  localparam int NumTimers = 3;

  localparam int CmdW    = 2;
  localparam int OffsetW = 6;
  localparam int WdataW  = 32;
  localparam int CyclesW = 16;
  localparam int RdataW  = 16;
  localparam int IrqW    = 3;
  localparam int CountW  = 16;
  localparam int ModeW   = 10;
  localparam int RegSelW = 4;
  localparam int TimerW  = OffsetW - RegSelW;
  localparam int NumTimersW = 3;

  localparam int NumIrq = (NumTimers < IrqW) ? NumTimers : IrqW;

  localparam int DivTimer = 2;
  localparam int Div8Shift = 3;

  localparam int BitResetOnTarget = 3;
  localparam int BitIrqOnTarget   = 4;
  localparam int BitIrqOnWrap     = 5;
  localparam int BitDiv8          = 8;

  typedef enum logic [CmdW-1:0] {
    CmdRead  = 2'd0,
    CmdWrite = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  localparam logic [RegSelW-1:0] RegCount  = 4'h0;
  localparam logic [RegSelW-1:0] RegMode   = 4'h4;
  localparam logic [RegSelW-1:0] RegTarget = 4'h8;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              target_hit;
    logic              wrap_hit;
    logic              irq;
  } adv_t;

endpackage

// ===== hdl/rct_in_if.sv =====
interface rct_in_if;
  logic                        valid;
  logic                        ready;
  logic [rct_pkg::CmdW-1:0]    command;
  logic [rct_pkg::OffsetW-1:0] offset;
  logic [rct_pkg::WdataW-1:0]  write_data;
  logic [rct_pkg::CyclesW-1:0] tick_cycles;

  modport source (output valid, command, offset, write_data, tick_cycles, input ready);
  modport sink (input valid, command, offset, write_data, tick_cycles, output ready);
endinterface

// ===== hdl/rct_out_if.sv =====
interface rct_out_if;
  logic                       valid;
  logic                       ready;
  logic [rct_pkg::RdataW-1:0] read_data;
  logic [rct_pkg::IrqW-1:0]   irq_fire;
  logic                       unmapped;

  modport source (output valid, read_data, irq_fire, unmapped, input ready);
  modport sink (input valid, read_data, irq_fire, unmapped, output ready);
endinterface

// ===== hdl/rct_advance.sv =====
module rct_advance (
  input  logic [rct_pkg::CountW-1:0]  count_i,
  input  logic [rct_pkg::ModeW-1:0]   mode_i,
  input  logic [rct_pkg::CountW-1:0]  target_i,
  input  logic [rct_pkg::CyclesW-1:0] cycles_i,
  input  logic                        div_timer_i,
  output rct_pkg::adv_t               adv_o
);

  logic [rct_pkg::CyclesW-1:0] inc;
  logic [rct_pkg::CountW:0]    sum;
  logic [rct_pkg::CountW:0]    cur;
  logic                        reached;

  always_comb begin
    inc = cycles_i;
    if (div_timer_i && mode_i[rct_pkg::BitDiv8]) begin
      inc = cycles_i >> rct_pkg::Div8Shift;
    end
    sum = {1'b0, count_i} + {{(rct_pkg::CountW + 1 - rct_pkg::CyclesW){1'b0}}, inc};
    reached = (target_i != '0) && (sum >= {1'b0, target_i});
    cur = sum;
    if (reached && mode_i[rct_pkg::BitResetOnTarget]) begin
      cur = '0;
    end
    adv_o.count      = cur[rct_pkg::CountW-1:0];
    adv_o.target_hit = reached;
    adv_o.wrap_hit   = cur[rct_pkg::CountW];
    adv_o.irq        = (reached && mode_i[rct_pkg::BitIrqOnTarget])
                    || (cur[rct_pkg::CountW] && mode_i[rct_pkg::BitIrqOnWrap]);
  end

endmodule

// ===== hdl/three_channel_root_counter_timer_core.sv =====
// Three 16-bit root counters behind one item channel: bus reads and writes of
// the counter, mode and target of each timer, and ticks that advance all
// timers at once. Every item gives exactly one result. Throughput is one item
// per clock while results are taken; an item is held in the input register,
// where decode and the per-timer add-compare run, and then sits in the result
// register, from which the result is offered. The input stays open while a
// result waits, holding one more item before the channel stalls.
module three_channel_root_counter_timer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  rct_in_if.sink      in_i,
  rct_out_if.source   out_o
);

  localparam int N = rct_pkg::NumTimers;

  logic                        s1_valid_q;
  logic [rct_pkg::CmdW-1:0]    s1_cmd_q;
  logic [rct_pkg::OffsetW-1:0] s1_offset_q;
  logic [rct_pkg::WdataW-1:0]  s1_wdata_q;
  logic [rct_pkg::CyclesW-1:0] s1_cycles_q;

  logic                        out_valid_q;
  logic [rct_pkg::RdataW-1:0]  rdata_q, rdata_d;
  logic [rct_pkg::IrqW-1:0]    irq_q, irq_d;
  logic                        unm_q, unm_d;

  logic [rct_pkg::CountW-1:0]  cnt_q [N];
  logic [rct_pkg::CountW-1:0]  cnt_d [N];
  logic [rct_pkg::ModeW-1:0]   mode_q [N];
  logic [rct_pkg::ModeW-1:0]   mode_d [N];
  logic [rct_pkg::CountW-1:0]  tgt_q [N];
  logic [rct_pkg::CountW-1:0]  tgt_d [N];
  logic [N-1:0]                hit_q, hit_d;
  logic [N-1:0]                wrap_q, wrap_d;

  rct_pkg::adv_t               adv [N];

  logic                        advance;
  logic                        s1_fire;
  logic                        in_fire;
  logic [rct_pkg::TimerW-1:0]  sel_timer;
  logic [rct_pkg::RegSelW-1:0] sel_reg;
  logic                        mapped;

  assign advance = !out_valid_q || out_o.ready;
  assign s1_fire = s1_valid_q && advance;
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire = in_i.valid && in_i.ready;

  assign sel_timer = s1_offset_q[rct_pkg::OffsetW-1:rct_pkg::RegSelW];
  assign sel_reg   = s1_offset_q[rct_pkg::RegSelW-1:0];
  assign mapped = ({1'b0, sel_timer} < rct_pkg::NumTimersW'(N))
               && ((sel_reg == rct_pkg::RegCount) || (sel_reg == rct_pkg::RegMode)
                || (sel_reg == rct_pkg::RegTarget));

  for (genvar g = 0; g < N; g++) begin : g_timer
    rct_advance u_advance (
      .count_i     (cnt_q[g]),
      .mode_i      (mode_q[g]),
      .target_i    (tgt_q[g]),
      .cycles_i    (s1_cycles_q),
      .div_timer_i (g == rct_pkg::DivTimer),
      .adv_o       (adv[g])
    );
  end

  always_comb begin
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    tgt_d   = tgt_q;
    hit_d   = hit_q;
    wrap_d  = wrap_q;
    rdata_d = '0;
    irq_d   = '0;
    unm_d   = 1'b0;
    if (s1_fire) begin
      case (rct_pkg::cmd_e'(s1_cmd_q))
        rct_pkg::CmdTick: begin
          for (int i = 0; i < N; i++) begin
            cnt_d[i]  = adv[i].count;
            hit_d[i]  = hit_q[i] | adv[i].target_hit;
            wrap_d[i] = wrap_q[i] | adv[i].wrap_hit;
          end
          for (int i = 0; i < rct_pkg::NumIrq; i++) begin
            irq_d[i] = adv[i].irq;
          end
        end
        rct_pkg::CmdRead: begin
          unm_d = !mapped;
          for (int i = 0; i < N; i++) begin
            if (mapped && (sel_timer == rct_pkg::TimerW'(i))) begin
              if (sel_reg == rct_pkg::RegCount) begin
                rdata_d = cnt_q[i];
              end else if (sel_reg == rct_pkg::RegMode) begin
                rdata_d = {3'b000, wrap_q[i], hit_q[i], 1'b0, mode_q[i]};
                hit_d[i]  = 1'b0;
                wrap_d[i] = 1'b0;
              end else begin
                rdata_d = tgt_q[i];
              end
            end
          end
        end
        rct_pkg::CmdWrite: begin
          unm_d = !mapped;
          for (int i = 0; i < N; i++) begin
            if (mapped && (sel_timer == rct_pkg::TimerW'(i))) begin
              if (sel_reg == rct_pkg::RegCount) begin
                cnt_d[i] = s1_wdata_q[rct_pkg::CountW-1:0];
              end else if (sel_reg == rct_pkg::RegMode) begin
                mode_d[i] = s1_wdata_q[rct_pkg::ModeW-1:0];
                cnt_d[i]  = '0;
                hit_d[i]  = 1'b0;
                wrap_d[i] = 1'b0;
              end else begin
                tgt_d[i] = s1_wdata_q[rct_pkg::CountW-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= '0;
      wrap_q      <= '0;
      for (int i = 0; i < N; i++) begin
        cnt_q[i]  <= '0;
        mode_q[i] <= '0;
        tgt_q[i]  <= '0;
      end
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
      tgt_q  <= tgt_d;
      hit_q  <= hit_d;
      wrap_q <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q    <= in_i.command;
      s1_offset_q <= in_i.offset;
      s1_wdata_q  <= in_i.write_data;
      s1_cycles_q <= in_i.tick_cycles;
    end
    if (s1_fire) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      unm_q   <= unm_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = rdata_q;
  assign out_o.irq_fire  = irq_q;
  assign out_o.unmapped  = unm_q;

endmodule
